@@ src/brsp_pkg.sv @@
`default_nettype none
package brsp_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned TYPE_W = 4;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [WORD_W-1:0] HDR_BYTES = 32'd8;
  localparam logic [TYPE_W-1:0] TYPE_MASK = 4'hF;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTORY_RVA = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTORY_SIZE = 8'd1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DIR_END = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SIZE_SMALL = 2'd2;
  localparam logic [KIND_W-1:0] KIND_OVERRUN = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] addr;
    logic [TYPE_W-1:0] etype;
    logic              last;
  } brsp_result_t;

  // results produced by one byte, in order: res0 first
  typedef struct packed {
    logic [1:0]   num;
    brsp_result_t res0;
    brsp_result_t res1;
  } brsp_push_t;

  // parse restart request from the register file
  typedef struct packed {
    logic              go;
    logic              rva_zero;
    logic [WORD_W-1:0] size;
  } brsp_restart_t;

endpackage
`default_nettype wire

@@ src/brsp_in_if.sv @@
`default_nettype none
interface brsp_in_if
  import brsp_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

@@ src/brsp_out_if.sv @@
`default_nettype none
interface brsp_out_if
  import brsp_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] result_kind;
  logic [WORD_W-1:0] entry_address;
  logic [TYPE_W-1:0] entry_type;
  logic              final_result;

  modport source (output valid, output result_kind, output entry_address,
                  output entry_type, output final_result, input ready);
  modport sink (input valid, input result_kind, input entry_address,
                input entry_type, input final_result, output ready);
endinterface
`default_nettype wire

@@ src/brsp_cfg_if.sv @@
`default_nettype none
interface brsp_cfg_if
  import brsp_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ src/brsp_parser.sv @@
`default_nettype none
module brsp_parser
  import brsp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire brsp_restart_t     restart,
  input  wire logic              in_take,
  input  wire logic [DATA_W-1:0] in_byte,
  output brsp_push_t             push
);

  typedef enum logic [1:0] {PH_HEADER, PH_LOW, PH_HIGH, PH_DONE} phase_t;

  phase_t              phase_r, phase_nxt;
  logic [WORD_W-1:0]   rem_r, rem_nxt;      // directory bytes left
  logic [WORD_W-1:0]   cnt_r, cnt_nxt;      // header count or body bytes left
  logic [2*WORD_W-1:0] hdr_r, hdr_nxt;
  logic [WORD_W-1:0]   page_r, page_nxt;
  logic [DATA_W-1:0]   low_r, low_nxt;
  logic                stage_valid_r;
  logic [DATA_W-1:0]   stage_byte_r;

  logic [WORD_W-1:0]   rem_dec;
  logic [2*WORD_W-1:0] shift_in;
  logic [WORD_W-1:0]   hdr_page;
  logic [WORD_W-1:0]   hdr_size;
  logic [WORD_W-1:0]   avail;
  logic [WORD_W-1:0]   body;
  logic [WORD_W-1:0]   cnt_after;
  logic                at_end;
  brsp_result_t        end_res;
  brsp_result_t        err_small;
  brsp_result_t        err_over;
  brsp_result_t        entry_res;

  assign rem_dec   = rem_r - 32'd1;
  assign shift_in  = {stage_byte_r, hdr_r[2*WORD_W-1:DATA_W]};
  assign hdr_page  = shift_in[WORD_W-1:0];
  assign hdr_size  = shift_in[2*WORD_W-1:WORD_W];
  assign avail     = rem_dec + HDR_BYTES;
  assign body      = hdr_size - HDR_BYTES;
  assign at_end    = rem_dec < HDR_BYTES;
  assign cnt_after = (cnt_r != '0) ? cnt_r - 32'd1 : '0;

  assign end_res   = '{kind: KIND_DIR_END, addr: '0, etype: '0, last: 1'b1};
  assign err_small = '{kind: KIND_SIZE_SMALL, addr: '0, etype: '0, last: 1'b1};
  assign err_over  = '{kind: KIND_OVERRUN, addr: '0, etype: '0, last: 1'b1};
  assign entry_res = '{kind: KIND_ENTRY,
                       addr: page_r + {20'd0, stage_byte_r[3:0], low_r},
                       etype: stage_byte_r[7:4] & TYPE_MASK,
                       last: 1'b0};

  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    hdr_nxt   = hdr_r;
    page_nxt  = page_r;
    low_nxt   = low_r;
    push      = '0;
    if (restart.go) begin
      phase_nxt = restart.rva_zero ? PH_DONE : PH_HEADER;
      rem_nxt   = restart.size;
      cnt_nxt   = '0;
    end else if (stage_valid_r) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (cnt_r == '0 && rem_r < HDR_BYTES) begin
            // short directory before a header
            phase_nxt = PH_DONE;
            push.num  = 2'd1;
            push.res0 = end_res;
          end else begin
            hdr_nxt = shift_in;
            rem_nxt = rem_dec;
            cnt_nxt = cnt_r + 32'd1;
            if (cnt_r == HDR_BYTES - 32'd1) begin
              if (hdr_page == '0 && hdr_size == '0) begin
                phase_nxt = PH_DONE;
                push.num  = 2'd1;
                push.res0 = end_res;
              end else if (hdr_size < HDR_BYTES) begin
                phase_nxt = PH_DONE;
                push.num  = 2'd1;
                push.res0 = err_small;
              end else if (hdr_size > avail) begin
                phase_nxt = PH_DONE;
                push.num  = 2'd1;
                push.res0 = err_over;
              end else begin
                page_nxt = hdr_page;
                cnt_nxt  = body;
                if (body == '0) begin
                  // empty block: straight to the next boundary
                  cnt_nxt = '0;
                  if (at_end) begin
                    phase_nxt = PH_DONE;
                    push.num  = 2'd1;
                    push.res0 = end_res;
                  end else begin
                    phase_nxt = PH_HEADER;
                  end
                end else begin
                  phase_nxt = PH_LOW;
                end
              end
            end
          end
        end
        PH_LOW: begin
          rem_nxt = rem_dec;
          if (cnt_r <= 32'd1) begin
            // odd trailing byte closes the block silently
            cnt_nxt = '0;
            if (at_end) begin
              phase_nxt = PH_DONE;
              push.num  = 2'd1;
              push.res0 = end_res;
            end else begin
              phase_nxt = PH_HEADER;
            end
          end else begin
            low_nxt   = stage_byte_r;
            cnt_nxt   = cnt_r - 32'd1;
            phase_nxt = PH_HIGH;
          end
        end
        PH_HIGH: begin
          rem_nxt   = rem_dec;
          cnt_nxt   = cnt_after;
          push.num  = 2'd1;
          push.res0 = entry_res;
          if (cnt_after == '0) begin
            if (at_end) begin
              phase_nxt = PH_DONE;
              push.num  = 2'd2;
              push.res1 = end_res;
            end else begin
              phase_nxt = PH_HEADER;
            end
          end else begin
            phase_nxt = PH_LOW;
          end
        end
        PH_DONE: begin
          phase_nxt = PH_DONE;
        end
        default: begin
          phase_nxt = PH_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_DONE;
      rem_r         <= '0;
      cnt_r         <= '0;
      stage_valid_r <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      rem_r         <= rem_nxt;
      cnt_r         <= cnt_nxt;
      stage_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r        <= hdr_nxt;
    page_r       <= page_nxt;
    low_r        <= low_nxt;
    stage_byte_r <= in_byte;
  end

  a_pair_is_entry_then_end: assert property (@(posedge clk) disable iff (!rst_n)
    push.num == 2'd2 |-> push.res0.kind == KIND_ENTRY && push.res1.last)
    else $error("two results must be an entry followed by the directory end");

  a_last_stops_parse: assert property (@(posedge clk) disable iff (!rst_n)
    (push.num != 2'd0 && !restart.go &&
     ((push.num == 2'd1 && push.res0.last) || push.num == 2'd2))
    |=> phase_r == PH_DONE)
    else $error("parse continued after its last result");

  a_no_result_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE |-> push.num == 2'd0)
    else $error("result produced after the parse ended");

endmodule
`default_nettype wire

@@ src/brsp_out_fifo.sv @@
`default_nettype none
module brsp_out_fifo
  import brsp_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire brsp_push_t   push,
  input  wire logic         pop,
  output brsp_result_t      head,
  output logic              not_empty,
  output logic              room
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  brsp_result_t     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0] wr_ptr_p1;

  assign wr_ptr_p1 = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
  assign head      = mem[rd_ptr_r];
  assign not_empty = count_r != '0;
  // a byte in flight may add two results, the next one two more
  assign room      = count_r <= CNT_W'(DEPTH - 4);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push.num == 2'd1) begin
      wr_ptr_nxt = wr_ptr_p1;
    end else if (push.num == 2'd2) begin
      wr_ptr_nxt = (wr_ptr_p1 == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_p1 + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    count_nxt = count_r + CNT_W'(push.num) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[wr_ptr_r] <= push.res0;
    end
    if (push.num == 2'd2) begin
      mem[wr_ptr_p1] <= push.res1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.num != 2'd0 |-> count_r <= CNT_W'(DEPTH) - CNT_W'(push.num))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("pop from empty result queue");

endmodule
`default_nettype wire

@@ src/base_relocation_stream_parser_core.sv @@
`default_nettype none
// Relocation directory stream parser. Raw directory bytes enter on in_ch,
// one byte per transaction, and the block walks the block headers and
// 16-bit entries, reporting on out_ch one transaction per entry (page plus
// 12-bit offset and the 4-bit type), plus a final transaction for the
// directory end or a header error. Throughput is one byte per clock while
// the result queue has room: each byte is registered, then a single stage
// of parse logic (one 32-bit add for the entry address, a few 32-bit
// compares on the header) updates the parse state and pushes up to two
// results into an 8-deep result queue. A result reaches the queue head once
// it is written into the queue memory and leaves from there on out_ch.
// in_ch.ready drops only while the result queue is close to full, so a
// short output stall does not back up the input. Writing either
// configuration register restarts the parse; write it only while idle. A
// directory address of zero disables the parser and bytes are dropped.
module base_relocation_stream_parser_core
  import brsp_pkg::*;
#(
  parameter int unsigned OUT_DEPTH = 8
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  brsp_in_if.sink    in_ch,
  brsp_out_if.source out_ch,
  brsp_cfg_if.sink   cfg_ch
);

  logic [WORD_W-1:0] rva_r, rva_nxt;
  logic [WORD_W-1:0] size_r, size_nxt;
  brsp_restart_t     restart;
  brsp_push_t        push;
  brsp_result_t      head;
  logic              not_empty;
  logic              room;
  logic              in_take;
  logic              out_take;
  logic              cfg_take;

  // config port never stalls
  assign cfg_ch.ready = 1'b1;
  assign cfg_take     = cfg_ch.valid && cfg_ch.ready;

  // register write decode, unknown indexes are dropped
  always_comb begin
    rva_nxt    = rva_r;
    size_nxt   = size_r;
    restart.go = 1'b0;
    if (cfg_take) begin
      unique case (cfg_ch.index)
        REG_DIRECTORY_RVA: begin
          rva_nxt    = cfg_ch.data;
          restart.go = 1'b1;
        end
        REG_DIRECTORY_SIZE: begin
          size_nxt   = cfg_ch.data;
          restart.go = 1'b1;
        end
        default: begin
          restart.go = 1'b0;
        end
      endcase
    end
    restart.rva_zero = rva_nxt == '0;
    restart.size     = size_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rva_r  <= '0;
      size_r <= '0;
    end else begin
      rva_r  <= rva_nxt;
      size_r <= size_nxt;
    end
  end

  // input side: one byte per transaction while the queue has headroom
  assign in_ch.ready = room;
  assign in_take     = in_ch.valid && in_ch.ready;

  brsp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (restart),
    .in_take (in_take),
    .in_byte (in_ch.data_byte),
    .push    (push)
  );

  // result side
  assign out_take = out_ch.valid && out_ch.ready;

  brsp_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (out_take),
    .head      (head),
    .not_empty (not_empty),
    .room      (room)
  );

  assign out_ch.valid         = not_empty;
  assign out_ch.result_kind   = head.kind;
  assign out_ch.entry_address = head.addr;
  assign out_ch.entry_type    = head.etype;
  assign out_ch.final_result  = head.last;

  a_cfg_restart_only_known: assert property (@(posedge clk) disable iff (!rst_n)
    restart.go |-> cfg_take &&
      (cfg_ch.index == REG_DIRECTORY_RVA || cfg_ch.index == REG_DIRECTORY_SIZE))
    else $error("restart without a register write");

endmodule
`default_nettype wire

@@ tb/brsp_result_checker.sv @@
`default_nettype none
module brsp_result_checker
  import brsp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_ready,
  input  wire logic [DATA_W-1:0]    in_data,
  input  wire logic                 out_valid,
  input  wire logic                 out_ready,
  input  wire logic [KIND_W-1:0]    out_kind,
  input  wire logic [WORD_W-1:0]    out_addr,
  input  wire logic [TYPE_W-1:0]    out_type,
  input  wire logic                 out_last,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data,
  output int unsigned               mismatch_count,
  output int unsigned               outstanding_results
);

  typedef enum logic [1:0] {
    PHASE_HEADER,
    PHASE_LOW,
    PHASE_HIGH,
    PHASE_DONE
  } parse_phase_e;

  logic [WORD_W-1:0] dir_rva;
  logic [WORD_W-1:0] dir_len;
  logic [WORD_W-1:0] consumed;
  logic [WORD_W-1:0] block_left;
  logic [WORD_W-1:0] page;
  logic [63:0]       hdr_shift;
  logic [7:0]        low_byte;
  parse_phase_e      phase;

  brsp_result_t expected_results[$];

  function void restart_parse();
    consumed   = '0;
    hdr_shift  = '0;
    block_left = '0;
    page       = '0;
    low_byte   = '0;
    phase      = (dir_rva == '0) ? PHASE_DONE : PHASE_HEADER;
  endfunction

  function void expect_result(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] addr,
                              input logic [TYPE_W-1:0] etype, input logic last);
    brsp_result_t r;
    r.kind  = kind;
    r.addr  = addr;
    r.etype = etype;
    r.last  = last;
    expected_results.insert(expected_results.size(), r);
  endfunction

  // end of a block: either the directory is exhausted or a new header follows
  function void close_block();
    if (dir_len - consumed < HDR_BYTES) begin
      phase = PHASE_DONE;
      expect_result(KIND_DIR_END, '0, '0, 1'b1);
    end else begin
      phase      = PHASE_HEADER;
      block_left = '0;
      hdr_shift  = '0;
    end
  endfunction

  function void parse_byte(input logic [DATA_W-1:0] b);
    logic [WORD_W-1:0] hdr_page;
    logic [WORD_W-1:0] hdr_size;
    logic [WORD_W-1:0] room;
    logic [15:0]       entry;
    case (phase)
      PHASE_HEADER: begin
        if (block_left == '0 && dir_len - consumed < HDR_BYTES) begin
          phase = PHASE_DONE;
          expect_result(KIND_DIR_END, '0, '0, 1'b1);
        end else begin
          hdr_shift  = {b, hdr_shift[63:8]};
          consumed   = consumed + 1;
          block_left = block_left + 1;
          if (block_left >= HDR_BYTES) begin
            hdr_page = hdr_shift[31:0];
            hdr_size = hdr_shift[63:32];
            room     = dir_len - (consumed - HDR_BYTES);
            if (hdr_page == '0 && hdr_size == '0) begin
              phase = PHASE_DONE;
              expect_result(KIND_DIR_END, '0, '0, 1'b1);
            end else if (hdr_size < HDR_BYTES) begin
              phase = PHASE_DONE;
              expect_result(KIND_SIZE_SMALL, '0, '0, 1'b1);
            end else if (hdr_size > room) begin
              phase = PHASE_DONE;
              expect_result(KIND_OVERRUN, '0, '0, 1'b1);
            end else begin
              page       = hdr_page;
              block_left = hdr_size - HDR_BYTES;
              if (block_left == '0) close_block();
              else phase = PHASE_LOW;
            end
          end
        end
      end
      PHASE_LOW: begin
        consumed = consumed + 1;
        if (block_left <= 1) begin
          // odd trailing byte
          block_left = '0;
          close_block();
        end else begin
          low_byte   = b;
          block_left = block_left - 1;
          phase      = PHASE_HIGH;
        end
      end
      PHASE_HIGH: begin
        entry    = {b, low_byte};
        consumed = consumed + 1;
        expect_result(KIND_ENTRY, page + {20'd0, entry[11:0]}, entry[15:12], 1'b0);
        if (block_left != '0) block_left = block_left - 1;
        if (block_left == '0) close_block();
        else phase = PHASE_LOW;
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    brsp_result_t seen;
    brsp_result_t want;
    if (!rst_n) begin
      dir_rva        = '0;
      dir_len        = '0;
      restart_parse();
      expected_results.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        seen.kind  = out_kind;
        seen.addr  = out_addr;
        seen.etype = out_type;
        seen.last  = out_last;
        if (expected_results.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          $display("%0t: unexpected result kind=%0d addr=%h type=%h last=%0b",
                   $time, seen.kind, seen.addr, seen.etype, seen.last);
        end else begin
          want = expected_results.pop_front();
          if (seen !== want) begin
            mismatch_count = mismatch_count + 1;
            $display({"%0t: expected kind=%0d addr=%h type=%h last=%0b, ",
                      "got kind=%0d addr=%h type=%h last=%0b"},
                     $time, want.kind, want.addr, want.etype, want.last,
                     seen.kind, seen.addr, seen.etype, seen.last);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_DIRECTORY_RVA) begin
          dir_rva = cfg_data;
          restart_parse();
        end else if (cfg_index == REG_DIRECTORY_SIZE) begin
          dir_len = cfg_data;
          restart_parse();
        end
      end
      if (in_valid && in_ready) parse_byte(in_data);
    end
    outstanding_results = expected_results.size();
  end

endmodule
`default_nettype wire

@@ tb/tb_base_relocation_stream_parser_core.sv @@
`default_nettype none
module tb_base_relocation_stream_parser_core;
  import brsp_pkg::*;

  // index with no register behind it, the block must ignore the write
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'd2;
  // bytes of random directories to push through
  localparam int unsigned RANDOM_BYTES = 2000;
  // length of the long output stall that backs the block up
  localparam int unsigned HOLD_CYCLES = 120;

  typedef enum int {
    IDLE_SENDER_LIGHT,  // sender idles rarely, receiver stalls a lot
    IDLE_SENDER_HEAVY,  // the other way round
    IDLE_NONE           // both sides at full rate
  } idle_mode_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #2 clk = ~clk;

  brsp_in_if  in_ch();
  brsp_out_if out_ch();
  brsp_cfg_if cfg_ch();

  base_relocation_stream_parser_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  int unsigned mismatch_count;
  int unsigned outstanding_results;

  brsp_result_checker parse_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_ch.valid),
    .in_ready            (in_ch.ready),
    .in_data             (in_ch.data_byte),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_kind            (out_ch.result_kind),
    .out_addr            (out_ch.entry_address),
    .out_type            (out_ch.entry_type),
    .out_last            (out_ch.final_result),
    .cfg_valid           (cfg_ch.valid),
    .cfg_ready           (cfg_ch.ready),
    .cfg_index           (cfg_ch.index),
    .cfg_data            (cfg_ch.data),
    .mismatch_count      (mismatch_count),
    .outstanding_results (outstanding_results)
  );

  idle_mode_e        idle_mode = IDLE_SENDER_LIGHT;
  int unsigned       hold_requests = 0;
  int unsigned       parsed_bytes = 0;
  logic [DATA_W-1:0] dir_stream[$];

  // append one byte to the directory image
  function automatic void add_byte(input logic [DATA_W-1:0] b);
    dir_stream.insert(dir_stream.size(), b);
  endfunction

  // directory image helpers, everything little endian
  function automatic void put_half(input logic [15:0] h);
    add_byte(h[7:0]);
    add_byte(h[15:8]);
  endfunction

  function automatic void put_word(input logic [WORD_W-1:0] w);
    put_half(w[15:0]);
    put_half(w[31:16]);
  endfunction

  // header plus a body of random entry bytes, odd lengths leave a trailing byte
  function automatic void put_block(input logic [WORD_W-1:0] page, input int unsigned body);
    put_word(page);
    put_word(HDR_BYTES + body);
    repeat (body) add_byte(DATA_W'($urandom));
  endfunction

  function automatic logic [WORD_W-1:0] random_page();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return '0;
    // near the top so that page plus offset wraps
    if (pick < 35) return 32'hFFFF_F000 | WORD_W'($urandom_range(4095));
    return WORD_W'($urandom);
  endfunction

  // one register transaction, valid is left high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  task automatic configure(input logic [WORD_W-1:0] rva, input logic [WORD_W-1:0] len);
    write_reg(REG_DIRECTORY_RVA, rva);
    write_reg(REG_DIRECTORY_SIZE, len);
    cfg_ch.valid <= 1'b0;
  endtask

  // push the directory image, one byte transaction at a time
  task automatic send_stream();
    int unsigned idle_pct;
    foreach (dir_stream[i]) begin
      idle_pct = (idle_mode == IDLE_SENDER_LIGHT) ? 11 :
                 (idle_mode == IDLE_SENDER_HEAVY) ? 73 : 0;
      while ($urandom_range(99) < idle_pct) begin
        in_ch.valid <= 1'b0;
        @(negedge clk);
      end
      in_ch.valid     <= 1'b1;
      in_ch.data_byte <= dir_stream[i];
      do @(posedge clk); while (!in_ch.ready);
      @(negedge clk);
    end
    in_ch.valid <= 1'b0;
    dir_stream.delete();
  endtask

  // wait for every predicted result, then give the pipeline time to go quiet
  // since the last bytes may produce nothing
  task automatic settle();
    repeat (4) @(negedge clk);
    while (outstanding_results != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic run_random_directory();
    logic [WORD_W-1:0] rva;
    logic [WORD_W-1:0] len;
    logic [WORD_W-1:0] total;
    logic [WORD_W-1:0] room;
    int unsigned       scenario;
    int unsigned       body;
    rva = WORD_W'($urandom);
    if (rva == '0) rva = 32'd1;
    total    = '0;
    scenario = $urandom_range(99);
    if (scenario < 4) begin
      // parser disabled, every byte dropped
      rva = '0;
      len = WORD_W'($urandom);
      repeat ($urandom_range(6, 20)) add_byte(DATA_W'($urandom));
    end else if (scenario < 9) begin
      // directory too short for even one header
      len = WORD_W'($urandom_range(7));
      repeat ($urandom_range(1, 3)) add_byte(DATA_W'($urandom));
      parsed_bytes += 1;
    end else if (scenario < 14) begin
      // raw noise, usually trips a header error quickly
      len = WORD_W'($urandom);
      repeat ($urandom_range(16, 48)) add_byte(DATA_W'($urandom));
      parsed_bytes += dir_stream.size();
    end else begin
      repeat ($urandom_range(1, 5)) begin
        body = ($urandom_range(9) == 0) ? $urandom_range(25, 60) : $urandom_range(16);
        put_block(random_page(), body);
        total = total + HDR_BYTES + body;
      end
      case ($urandom_range(4))
        0: begin
          // terminating all-zero header, possibly with slack behind it
          len = total + HDR_BYTES + WORD_W'($urandom_range(40));
          put_word('0);
          put_word('0);
        end
        1: begin
          // ends at a block boundary with under eight bytes left
          len = total + WORD_W'($urandom_range(7));
        end
        2: begin
          // block size below the header length
          len = total + HDR_BYTES + WORD_W'($urandom_range(40));
          put_word(random_page());
          put_word(WORD_W'($urandom_range(7)));
        end
        3: begin
          // block runs past the directory end
          len  = total + HDR_BYTES + WORD_W'($urandom_range(40));
          room = len - total;
          put_word(random_page());
          if ($urandom_range(1) == 0) put_word(room + 1 + WORD_W'($urandom_range(64)));
          else put_word(32'hFFFF_FFFF - WORD_W'($urandom_range(3)));
          repeat ($urandom_range(4)) add_byte(DATA_W'($urandom));
        end
        default: begin
          // directory continues past the end of the stream
          len = ($urandom_range(1) == 0) ? 32'hFFFF_FFFF :
                total + HDR_BYTES + WORD_W'($urandom_range(100, 5000));
        end
      endcase
      parsed_bytes += dir_stream.size();
      // stray bytes after the parse has ended are ignored
      repeat ($urandom_range(3)) add_byte(DATA_W'($urandom));
    end
    configure(rva, len);
    send_stream();
    settle();
  endtask

  // result side: random stalls per idle mode, plus one long hold on request
  initial begin
    int unsigned hold_seen;
    int unsigned hold_left;
    int unsigned stall_pct;
    hold_seen    = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      stall_pct = (idle_mode == IDLE_SENDER_LIGHT) ? 73 :
                  (idle_mode == IDLE_SENDER_HEAVY) ? 11 : 0;
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    bit pressure_done;
    pressure_done   = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directory address is zero after reset, so these bytes are dropped
    add_byte(8'h00);
    add_byte(8'hFF);
    send_stream();
    settle();

    // short directory: first byte reports the end, the second is dropped
    configure(32'd1, 32'd7);
    add_byte(8'hA5);
    add_byte(8'h5A);
    send_stream();
    settle();

    // entry with all ones wraps the address, then completes the block and
    // the directory end follows from the same byte
    configure(32'hFFFF_FFFF, 32'd12);
    put_word(32'hFFFF_FFF0);
    put_word(32'd10);
    put_half(16'hFFFF);
    send_stream();
    settle();

    // block size below eight
    configure(32'h0000_1000, 32'd64);
    put_word(32'h0040_0000);
    put_word(32'd5);
    send_stream();
    settle();

    // write to an unused index, then a block that overruns the directory
    write_reg(REG_UNMAPPED, WORD_W'($urandom));
    configure(32'h0000_1000, 32'd16);
    put_word(32'h0000_2000);
    put_word(32'h0000_0020);
    send_stream();
    settle();

    while (parsed_bytes < RANDOM_BYTES) begin
      idle_mode <= (parsed_bytes < RANDOM_BYTES / 3)     ? IDLE_SENDER_LIGHT :
                   (parsed_bytes < 2 * RANDOM_BYTES / 3) ? IDLE_SENDER_HEAVY : IDLE_NONE;
      @(negedge clk);
      if (idle_mode == IDLE_NONE && !pressure_done) begin
        // one long block while the output is held off, the result queue
        // fills and the input has to stall
        pressure_done = 1'b1;
        configure(WORD_W'($urandom) | 32'd1, 32'd308);
        put_block(random_page(), 300);
        parsed_bytes += dir_stream.size();
        hold_requests++;
        send_stream();
        settle();
      end
      run_random_directory();
    end

    settle();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && outstanding_results == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
